@@ rtl/fsbrt_pkg.sv @@
// ----------------------------------------------------------------------------
// fsbrt_pkg
// shared types and codes of the source block reception tracker
// ----------------------------------------------------------------------------
package fsbrt_pkg;

  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_BLK_RANGE = 3'd2;
  localparam logic [2:0] ST_SYM_RANGE = 3'd3;
  localparam logic [2:0] ST_OVER      = 3'd4;

  localparam logic [1:0] CFG_TRANSFER_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_SYMBOL_LENGTH    = 2'd1;
  localparam logic [1:0] CFG_MAX_BLOCK_LENGTH = 2'd2;

  localparam int LEN_W = 11;

  typedef struct packed {
    logic [31:0]      t;
    logic [15:0]      e;
    logic [31:0]      z;
    logic [31:0]      nlarge;
    logic [LEN_W-1:0] large_len;
    logic [LEN_W-1:0] small_len;
  } part_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [15:0]      blk;
    logic [15:0]      flat;
    logic [LEN_W-1:0] len;
    logic [31:0]      offset;
  } item_t;

endpackage

@@ rtl/fsbrt_part.sv @@
// ----------------------------------------------------------------------------
// fsbrt_part
// configuration registers and partition solver on a shared serial divider
// ----------------------------------------------------------------------------
module fsbrt_part import fsbrt_pkg::*; #(
  parameter int MAX_BLOCK_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        cfg_restart,
  output logic        ready,
  output part_t       part
);

  localparam logic [2:0] P_INIT = 3'd0;
  localparam logic [2:0] P_N    = 3'd1;
  localparam logic [2:0] P_Z    = 3'd2;
  localparam logic [2:0] P_L    = 3'd3;
  localparam logic [2:0] P_DONE = 3'd4;

  logic [31:0]      t;
  logic [15:0]      e;
  logic [10:0]      mbl;
  logic [10:0]      blsat;
  logic [2:0]       pst;
  logic [31:0]      dvd;
  logic [31:0]      dvs;
  logic [31:0]      rem;
  logic [4:0]       cnt;
  logic [31:0]      n;
  logic [32:0]      rem_sh;
  logic [32:0]      diff;
  logic             qbit;
  logic [31:0]      rnext;
  logic [31:0]      qfin;
  logic [31:0]      qceil;
  logic [31:0]      z;
  logic [31:0]      nlarge;
  logic [LEN_W-1:0] large_len;
  logic [LEN_W-1:0] small_len;

  assign blsat = ({6'b0, mbl} > 17'(MAX_BLOCK_LEN)) ? 11'(MAX_BLOCK_LEN) : mbl;
  assign rem_sh = {rem, dvd[31]};
  assign diff = rem_sh - {1'b0, dvs};
  assign qbit = !diff[32];
  assign rnext = qbit ? diff[31:0] : rem_sh[31:0];
  assign qfin = {dvd[30:0], qbit};
  assign qceil = qfin + {31'b0, (rnext != 32'd0)};
  assign cfg_restart = cfg_wr && (cfg_index == CFG_TRANSFER_LENGTH ||
                       cfg_index == CFG_SYMBOL_LENGTH || cfg_index == CFG_MAX_BLOCK_LENGTH);
  assign ready = (pst == P_DONE);
  assign part.t = t;
  assign part.e = e;
  assign part.z = z;
  assign part.nlarge = nlarge;
  assign part.large_len = large_len;
  assign part.small_len = small_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      t <= 32'd0;
      e <= 16'd1024;
      mbl <= 11'd64;
      pst <= P_INIT;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_TRANSFER_LENGTH: t <= cfg_data;
        CFG_SYMBOL_LENGTH: e <= cfg_data[15:0];
        CFG_MAX_BLOCK_LENGTH: mbl <= cfg_data[10:0];
        default: ;
      endcase
      if (cfg_restart) pst <= P_INIT;
    end else begin
      case (pst)
        P_INIT: begin
          if (e == 16'd0 || blsat == 11'd0) begin
            z <= 32'd0;
            nlarge <= 32'd0;
            large_len <= '0;
            small_len <= '0;
            pst <= P_DONE;
          end else begin
            dvd <= t;
            dvs <= {16'b0, e};
            rem <= 32'd0;
            cnt <= 5'd0;
            pst <= P_N;
          end
        end
        P_N, P_Z, P_L: begin
          if (cnt == 5'd31) begin
            rem <= 32'd0;
            cnt <= 5'd0;
            case (pst)
              P_N: begin
                n <= qceil;
                if (qceil == 32'd0) begin
                  z <= 32'd0;
                  nlarge <= 32'd0;
                  large_len <= '0;
                  small_len <= '0;
                  pst <= P_DONE;
                end else begin
                  dvd <= qceil;
                  dvs <= {21'b0, blsat};
                  pst <= P_Z;
                end
              end
              P_Z: begin
                z <= qceil;
                dvd <= n;
                dvs <= qceil;
                pst <= P_L;
              end
              default: begin
                small_len <= qfin[LEN_W-1:0];
                large_len <= qceil[LEN_W-1:0];
                nlarge <= rnext;
                pst <= P_DONE;
              end
            endcase
          end else begin
            dvd <= qfin;
            rem <= rnext;
            cnt <= cnt + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/fsbrt_front.sv @@
// ----------------------------------------------------------------------------
// fsbrt_front
// classifies an arriving symbol against the partition and finds its offset
// ----------------------------------------------------------------------------
module fsbrt_front import fsbrt_pkg::*; #(
  parameter int MAX_SYMBOLS = 4096,
  parameter int MAX_BLOCKS  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  part_t       part,
  input  logic        in_valid,
  input  logic        in_open,
  input  logic [15:0] block_number,
  input  logic [15:0] encoding_symbol_id,
  output logic        idle,
  output logic        push,
  output item_t       item,
  input  logic        q_full
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_ADD  = 3'd2;
  localparam logic [2:0] F_OFF  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]       fst;
  logic [15:0]      b;
  logic [15:0]      id;
  logic [26:0]      prod;
  logic [15:0]      minb;
  logic [LEN_W-1:0] len;
  logic             inrange;
  logic             islarge;
  logic [28:0]      flat;
  logic [2:0]       st;
  logic [15:0]      flatr;

  assign idle = (fst == F_IDLE);
  assign push = (fst == F_PUSH) && !q_full;
  assign islarge = {16'b0, b} < part.nlarge;
  assign flat = {2'b0, prod} + {13'b0, minb} + {13'b0, id};

  always_ff @(posedge clk) begin
    if (rst) begin
      fst <= F_IDLE;
    end else begin
      case (fst)
        F_IDLE: begin
          if (in_valid && in_open) begin
            b <= block_number;
            id <= encoding_symbol_id;
            fst <= F_MUL;
          end
        end
        F_MUL: begin
          prod <= 27'(b) * 27'(part.small_len);
          minb <= islarge ? b : part.nlarge[15:0];
          len <= islarge ? part.large_len : part.small_len;
          inrange <= {16'b0, b} < part.z;
          fst <= F_ADD;
        end
        F_ADD: begin
          if (!inrange) st <= ST_BLK_RANGE;
          else if (id >= {5'b0, len}) st <= ST_SYM_RANGE;
          else if (flat >= 29'(MAX_SYMBOLS) || {1'b0, b} >= 17'(MAX_BLOCKS)) st <= ST_OVER;
          else st <= ST_NEW;
          flatr <= flat[15:0];
          fst <= F_OFF;
        end
        F_OFF: begin
          item.status <= st;
          item.blk <= b;
          item.flat <= flatr;
          item.len <= len;
          item.offset <= 32'(flatr) * 32'(part.e);
          fst <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) fst <= F_IDLE;
        end
        default: fst <= F_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/fsbrt_queue.sv @@
// ----------------------------------------------------------------------------
// fsbrt_queue
// two-entry queue between classification and the bitmap update
// ----------------------------------------------------------------------------
module fsbrt_queue import fsbrt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  item_t      entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign full = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign head = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        entries[wptr] <= push_item;
        wptr <= ~wptr;
      end
      if (pop) rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/fsbrt_back.sv @@
// ----------------------------------------------------------------------------
// fsbrt_back
// received bitmap and block counts, clearing pass and result register
// ----------------------------------------------------------------------------
module fsbrt_back import fsbrt_pkg::*; #(
  parameter int MAX_SYMBOLS = 4096,
  parameter int MAX_BLOCKS  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        clr_start,
  output logic        clearing,
  input  part_t       part,
  input  logic        q_valid,
  input  item_t       q_head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,
  output logic [2:0]  m_tuser
);

  localparam int SW    = $clog2(MAX_SYMBOLS);
  localparam int BW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int CLR_N = (MAX_SYMBOLS > MAX_BLOCKS) ? MAX_SYMBOLS : MAX_BLOCKS;
  localparam int CLW   = $clog2(CLR_N);

  logic             bitmap [MAX_SYMBOLS];
  logic [LEN_W-1:0] counts [MAX_BLOCKS];
  logic [CLW-1:0]   clr_cnt;
  logic             ex;
  item_t            cur;
  logic             bit_rd;
  logic [LEN_W-1:0] cnt_rd;
  logic [CW-1:0]    ccount;
  logic [CW-1:0]    ccount_next;
  logic             good;
  logic             isnew;
  logic [LEN_W-1:0] cnt_new;
  logic             bc;
  logic [31:0]      remain;
  logic [15:0]      bytes;

  assign pop = !clearing && !ex && q_valid && (!m_tvalid || m_tready);
  assign good = (cur.status == ST_NEW);
  assign isnew = good && !bit_rd;
  assign cnt_new = cnt_rd + {{(LEN_W-1){1'b0}}, isnew};
  assign bc = good && (cnt_new == cur.len);
  assign ccount_next = ccount + {{(CW-1){1'b0}}, (isnew && cnt_new == cur.len)};
  assign remain = part.t - cur.offset;
  assign bytes = (remain > {16'b0, part.e}) ? part.e : remain[15:0];

  always_ff @(posedge clk) begin
    if (clearing) begin
      if ({{(32-CLW){1'b0}}, clr_cnt} < 32'(MAX_SYMBOLS)) bitmap[clr_cnt[SW-1:0]] <= 1'b0;
      if ({{(32-CLW){1'b0}}, clr_cnt} < 32'(MAX_BLOCKS)) counts[clr_cnt[BW-1:0]] <= '0;
    end else if (ex && isnew) begin
      bitmap[cur.flat[SW-1:0]] <= 1'b1;
      counts[cur.blk[BW-1:0]] <= cnt_new;
    end
    if (pop) begin
      bit_rd <= bitmap[q_head.flat[SW-1:0]];
      cnt_rd <= counts[q_head.blk[BW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt <= '0;
      ccount <= '0;
      ex <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (clr_start) begin
        clearing <= 1'b1;
        clr_cnt <= '0;
        ccount <= '0;
      end else if (clearing) begin
        if (clr_cnt == CLW'(CLR_N - 1)) clearing <= 1'b0;
        clr_cnt <= clr_cnt + CLW'(1);
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (pop) begin
        cur <= q_head;
        ex <= 1'b1;
      end
      if (ex) begin
        ex <= 1'b0;
        ccount <= ccount_next;
        m_tvalid <= 1'b1;
        m_tuser <= good ? (bit_rd ? ST_DUP : ST_NEW) : cur.status;
        m_tdata <= {6'b0,
                    (part.z != 32'd0) && ({{(32-CW){1'b0}}, ccount_next} == part.z),
                    bc, good ? bytes : 16'd0, good ? cur.offset : 32'd0};
      end
    end
  end

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_NEW || m_tuser == ST_DUP || m_tuser == ST_BLK_RANGE ||
                  m_tuser == ST_SYM_RANGE || m_tuser == ST_OVER))
    else $error("result status out of range");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_BLK_RANGE || m_tuser == ST_SYM_RANGE || m_tuser == ST_OVER)
    |-> m_tdata[48:0] == 49'd0)
    else $error("rejected item carries offset, length or block flag");

  a_ccount_bound: assert property (@(posedge clk) disable iff (rst)
    {{(32-CW){1'b0}}, ccount} <= 32'(MAX_BLOCKS))
    else $error("complete block count above block capacity");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("item taken during clearing pass");

endmodule

@@ rtl/fec_source_block_reception_tracker.sv @@
// ----------------------------------------------------------------------------
// fec_source_block_reception_tracker
// source block partition check, received bitmap and completion tracking
// ----------------------------------------------------------------------------
// an accepted item passes the classification states (multiply, add, offset,
// push), the two-entry queue, the bitmap and count read and the result register
// a new item is taken only when the sequencer is back in idle; reset or a write
// to cfg_index 0 to 2: partition solve on the serial divider and a clearing
// pass over the bitmap and block counts, s_tready stays low until both finish
module fec_source_block_reception_tracker import fsbrt_pkg::*; #(
  parameter int MAX_SYMBOLS   = 4096,
  parameter int MAX_BLOCKS    = 256,
  parameter int MAX_BLOCK_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // block_number, encoding_symbol_id
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // byte_offset, symbol_bytes, block_complete, object_complete
  output logic [2:0]  m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  part_t part;
  item_t fitem;
  item_t qhead;
  logic  part_ready;
  logic  restart;
  logic  clearing;
  logic  fidle;
  logic  fpush;
  logic  qfull;
  logic  qvalid;
  logic  qpop;

  assign cfg_ready = 1'b1;
  assign s_tready = fidle && part_ready && !clearing;

  fsbrt_part #(.MAX_BLOCK_LEN(MAX_BLOCK_LEN)) u_part (
    .clk(clk), .rst(rst), .cfg_wr(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg_restart(restart), .ready(part_ready), .part(part)
  );

  fsbrt_front #(.MAX_SYMBOLS(MAX_SYMBOLS), .MAX_BLOCKS(MAX_BLOCKS)) u_front (
    .clk(clk), .rst(rst), .part(part), .in_valid(s_tvalid),
    .in_open(part_ready && !clearing), .block_number(s_tdata[15:0]),
    .encoding_symbol_id(s_tdata[31:16]), .idle(fidle), .push(fpush),
    .item(fitem), .q_full(qfull)
  );

  fsbrt_queue u_queue (
    .clk(clk), .rst(rst), .push(fpush), .push_item(fitem), .full(qfull),
    .pop(qpop), .valid(qvalid), .head(qhead)
  );

  fsbrt_back #(.MAX_SYMBOLS(MAX_SYMBOLS), .MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk(clk), .rst(rst), .clr_start(restart), .clearing(clearing), .part(part),
    .q_valid(qvalid), .q_head(qhead), .pop(qpop), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule
